>>> hdl/srm_pkg.sv
// shared types and constants for the step response metrics block
// used by every module in hdl; depends on nothing

package srm_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int TIME_W = 32;
  localparam int POS_W  = 24;
  localparam int MAG_W  = 24;
  localparam int PEAK_W = 23;
  localparam int BAND_W = 23;
  localparam int SUM_W  = 64;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ROOT_W = SUM_W / 2;
  localparam int RUN_W  = 17;
  localparam int RMS_W  = 23;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [BAND_W-1:0]       BAND_RESET = 23'd410;
  localparam logic signed [POS_W:0]   ERR_MAX    = 25'sd8388607;
  localparam logic signed [POS_W:0]   ERR_MIN    = -25'sd8388608;
  localparam logic [RMS_W-1:0]        RMS_MAX    = 23'h7FFFFF;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one finished run, waiting for the divide and root
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [PEAK_W-1:0] peak;
    logic [MAG_W-1:0]  final_err;
    logic [TIME_W-1:0] settle_time;
    logic              settled;
    logic              sat;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_t;

endpackage

>>> hdl/srm_front.sv
// front part: sample transfer, error clamp, square and per-run accumulation
// depends on srm_pkg; hands finished runs to srm_queue

module srm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srm_pkg::BAND_W-1:0]        cfg_settling_band,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srm_pkg::TIME_W-1:0]        in_sample_time,
  input  logic signed [srm_pkg::POS_W-1:0]  in_target_position,
  input  logic signed [srm_pkg::POS_W-1:0]  in_measured_position,
  input  logic                              in_end_of_run,
  output srm_pkg::q_wr_t                    q_wr,
  input  logic                              q_full
);
  import srm_pkg::*;

  logic [BAND_W-1:0] band_r;

  logic signed [POS_W:0]   err_wide;
  logic signed [POS_W-1:0] err_clamped;
  logic [MAG_W-1:0]        mag;
  logic                    clamp;
  logic                    adv;

  // stage a: clamped error
  logic                    a_valid_r;
  logic [TIME_W-1:0]       a_time_r;
  logic signed [POS_W-1:0] a_err_r;
  logic [MAG_W-1:0]        a_mag_r;
  logic                    a_clamp_r;
  logic                    a_last_r;

  // stage b: squared error
  logic                    b_valid_r;
  logic [TIME_W-1:0]       b_time_r;
  logic signed [POS_W-1:0] b_err_r;
  logic [MAG_W-1:0]        b_mag_r;
  logic [SQ_W-1:0]         b_sq_r;
  logic                    b_clamp_r;
  logic                    b_last_r;

  // run state
  logic [SUM_W-1:0]  sum_r,   sum_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [PEAK_W-1:0] peak_r,  peak_nxt;
  logic [TIME_W-1:0] entry_r, entry_nxt;
  logic              inband_r, inband_nxt;
  logic              ovf_r,   ovf_nxt;
  logic [SUM_W:0]    sum_ext;
  logic              push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= BAND_RESET;
    end else if (cfg_valid) begin
      band_r <= cfg_settling_band;
    end
  end

  // a stalled report holds the whole pipe
  assign push     = b_valid_r && b_last_r && !q_full;
  assign adv      = !(b_valid_r && b_last_r && q_full);
  assign in_ready = adv;

  assign err_wide = {in_measured_position[POS_W-1], in_measured_position}
                  - {in_target_position[POS_W-1], in_target_position};

  always_comb begin
    clamp = 1'b0;
    if (err_wide > ERR_MAX) begin
      err_clamped = ERR_MAX[POS_W-1:0];
      clamp       = 1'b1;
    end else if (err_wide < ERR_MIN) begin
      err_clamped = ERR_MIN[POS_W-1:0];
      clamp       = 1'b1;
    end else begin
      err_clamped = err_wide[POS_W-1:0];
    end
    mag = err_clamped[POS_W-1] ? MAG_W'(~err_clamped + 1'b1) : MAG_W'(err_clamped);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_time_r  <= in_sample_time;
      a_err_r   <= err_clamped;
      a_mag_r   <= mag;
      a_clamp_r <= clamp;
      a_last_r  <= in_end_of_run;
      b_time_r  <= a_time_r;
      b_err_r   <= a_err_r;
      b_mag_r   <= a_mag_r;
      b_sq_r    <= a_mag_r * a_mag_r;
      b_clamp_r <= a_clamp_r;
      b_last_r  <= a_last_r;
    end
  end

  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    peak_nxt   = peak_r;
    entry_nxt  = entry_r;
    inband_nxt = inband_r;
    ovf_nxt    = ovf_r | b_clamp_r;
    sum_ext    = {1'b0, sum_r} + (SUM_W + 1)'(b_sq_r);

    if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (sum_ext[SUM_W]) begin
        sum_nxt = '1;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_ext[SUM_W-1:0];
      end
    end else begin
      ovf_nxt = 1'b1;
    end

    if (!b_err_r[POS_W-1] && (b_err_r != '0) && (b_err_r[PEAK_W-1:0] > peak_r)) begin
      peak_nxt = b_err_r[PEAK_W-1:0];
    end

    if (b_mag_r <= MAG_W'(band_r)) begin
      if (!inband_r) begin
        inband_nxt = 1'b1;
        entry_nxt  = b_time_r;
      end
    end else begin
      inband_nxt = 1'b0;
    end
  end

  always_comb begin
    q_wr.valid           = push;
    q_wr.job.sum         = sum_nxt;
    q_wr.job.count       = cnt_nxt;
    q_wr.job.peak        = peak_nxt;
    q_wr.job.final_err   = b_mag_r;
    q_wr.job.settle_time = inband_nxt ? entry_nxt : b_time_r;
    q_wr.job.settled     = inband_nxt;
    q_wr.job.sat         = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      peak_r   <= '0;
      entry_r  <= '0;
      inband_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (b_valid_r && adv) begin
      if (b_last_r) begin
        sum_r    <= '0;
        cnt_r    <= '0;
        peak_r   <= '0;
        entry_r  <= '0;
        inband_r <= 1'b0;
        ovf_r    <= 1'b0;
      end else begin
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
        peak_r   <= peak_nxt;
        entry_r  <= entry_nxt;
        inband_r <= inband_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

endmodule

>>> hdl/srm_queue.sv
// short report queue between the front and back parts
// depends on srm_pkg

module srm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  srm_pkg::q_wr_t q_wr,
  output logic           q_full,
  output srm_pkg::q_rd_t q_rd,
  input  logic           q_pop
);
  import srm_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign q_full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.job   = mem_r[rd_ptr_r];
  assign do_wr      = q_wr.valid && !q_full;
  assign do_rd      = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/srm_back.sv
// back part: mean square by bit-serial divide, then digit-serial square root
// depends on srm_pkg; reads reports from srm_queue

module srm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srm_pkg::q_rd_t              q_rd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srm_pkg::RMS_W-1:0]   out_rms_error,
  output logic [srm_pkg::PEAK_W-1:0]  out_peak_overshoot,
  output logic [srm_pkg::MAG_W-1:0]   out_final_error,
  output logic [srm_pkg::TIME_W-1:0]  out_settling_time,
  output logic                        out_settled,
  output logic [srm_pkg::RUN_W-1:0]   out_run_samples,
  output logic                        out_saturated
);
  import srm_pkg::*;

  back_state_t         state_r, state_nxt;
  job_t                job_r;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]    rad_r, rad_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [ROOT_W+1:0]   srem_r, srem_nxt;
  logic [RMS_W-1:0]    rms_r, rms_nxt;
  logic                sat_r, sat_nxt;

  logic [CNT_W:0]      rem_sh;
  logic [ROOT_W+3:0]   srem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    rms_nxt   = rms_r;
    sat_nxt   = sat_r;
    load      = 1'b0;
    q_pop     = 1'b0;
    rem_sh    = {rem_r, dvd_r[SUM_W-1]};
    srem_sh   = {srem_r, rad_r[SUM_W-1 -: 2]};
    trial     = (ROOT_W + 4)'({root_r, 2'b01});

    case (state_r)
      BK_IDLE: begin
        if (q_rd.valid) begin
          q_pop     = 1'b1;
          load      = 1'b1;
          dvd_nxt   = q_rd.job.sum;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (rem_sh >= {1'b0, job_r.count}) begin
          rem_nxt = CNT_W'(rem_sh - {1'b0, job_r.count});
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          rad_nxt   = dvd_nxt;
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        // one root bit per cycle, two radicand bits consumed
        if (srem_sh >= trial) begin
          srem_nxt = (ROOT_W + 2)'(srem_sh - trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = srem_sh[ROOT_W+1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        rad_nxt  = {rad_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          if (root_nxt > ROOT_W'(RMS_MAX)) begin
            rms_nxt = RMS_MAX;
            sat_nxt = 1'b1;
          end else begin
            rms_nxt = root_nxt[RMS_W-1:0];
            sat_nxt = job_r.sat;
          end
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_rd.job;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    rms_r  <= rms_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_valid          = (state_r == BK_OUT);
  assign out_rms_error      = rms_r;
  assign out_peak_overshoot = job_r.peak;
  assign out_final_error    = job_r.final_err;
  assign out_settling_time  = job_r.settle_time;
  assign out_settled        = job_r.settled;
  assign out_run_samples    = RUN_W'(job_r.count);
  assign out_saturated      = sat_r;

endmodule

>>> hdl/step_response_metrics.sv
// top level of the step response metrics block
// depends on srm_pkg, srm_front, srm_queue and srm_back
//
// usage
//   in_*  : one sample per transfer (time, target, measured, end-of-run mark)
//   out_* : one report per run, issued for the sample marked end_of_run
//   cfg_* : settling band write, always ready; write only while the block is idle
// throughput
//   samples: one per cycle; the front pipe (clamp, square, accumulate) never
//   waits on a sample, only on a full report queue
//   reports: the back part runs the bit-serial divide and then the square root
//   for each report and takes no new one until that is done; two more runs can
//   sit finished in the queue meanwhile
// report path
//   end-of-run sample through stages a and b, the queue, divide and root to out_valid
// reset
//   synchronous, active low; run figures clear, band returns to 410 (0.1 m)
// stall
//   a report held on out_ready blocks only the back part; samples keep flowing
//   until the queue fills and a further end-of-run sample reaches the
//   accumulator, then in_ready drops

module step_response_metrics (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srm_pkg::BAND_W-1:0]        cfg_settling_band,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srm_pkg::TIME_W-1:0]        in_sample_time,
  input  logic signed [srm_pkg::POS_W-1:0]  in_target_position,
  input  logic signed [srm_pkg::POS_W-1:0]  in_measured_position,
  input  logic                              in_end_of_run,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srm_pkg::RMS_W-1:0]         out_rms_error,
  output logic [srm_pkg::PEAK_W-1:0]        out_peak_overshoot,
  output logic [srm_pkg::MAG_W-1:0]         out_final_error,
  output logic [srm_pkg::TIME_W-1:0]        out_settling_time,
  output logic                              out_settled,
  output logic [srm_pkg::RUN_W-1:0]         out_run_samples,
  output logic                              out_saturated
);
  import srm_pkg::*;

  // finished run from the accumulator toward the queue
  q_wr_t q_wr;
  logic  q_full;
  // head of the queue toward the divide / root sequencer
  q_rd_t q_rd;
  logic  q_pop;

  srm_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_settling_band    (cfg_settling_band),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_time       (in_sample_time),
    .in_target_position   (in_target_position),
    .in_measured_position (in_measured_position),
    .in_end_of_run        (in_end_of_run),
    .q_wr                 (q_wr),
    .q_full               (q_full)
  );

  // decouples sample flow from the slow report math
  srm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // mean square, root and the output register
  srm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_rd               (q_rd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rms_error      (out_rms_error),
    .out_peak_overshoot (out_peak_overshoot),
    .out_final_error    (out_final_error),
    .out_settling_time  (out_settling_time),
    .out_settled        (out_settled),
    .out_run_samples    (out_run_samples),
    .out_saturated      (out_saturated)
  );

endmodule

>>> hdl/srm_checker.sv
// port-level checks on the step response metrics block, bound to the top level
// depends on srm_pkg and step_response_metrics

module srm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [srm_pkg::RMS_W-1:0]         out_rms_error,
  input logic [srm_pkg::PEAK_W-1:0]        out_peak_overshoot,
  input logic [srm_pkg::MAG_W-1:0]         out_final_error,
  input logic [srm_pkg::TIME_W-1:0]        out_settling_time,
  input logic                              out_settled,
  input logic [srm_pkg::RUN_W-1:0]         out_run_samples,
  input logic                              out_saturated
);
  import srm_pkg::*;

  // a waiting report stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rms_error)
      && $stable(out_peak_overshoot) && $stable(out_final_error)
      && $stable(out_settling_time) && $stable(out_settled)
      && $stable(out_run_samples) && $stable(out_saturated))
    else $error("report changed while stalled");

  // every run counts at least its first sample
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_samples != '0)
    else $error("report with zero samples");

  // zero final error is always inside the band
  a_unsettled_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_settled |-> out_final_error != '0)
    else $error("unsettled report with zero final error");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report right after reset");

endmodule

bind step_response_metrics srm_checker u_srm_checker (.*);

>>> dv/tb_top.sv
// self-checking testbench for step_response_metrics: samples in, per-run reports out
// depends on srm_pkg and the step_response_metrics rtl in hdl

module tb_top;
  import srm_pkg::*;

  // generous bound, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // extra wait after the last report, before the next phase
  localparam int unsigned DRAIN_CYCLES = 160;

  typedef struct {
    logic [TIME_W-1:0]        stamp;
    logic signed [POS_W-1:0]  tgt;
    logic signed [POS_W-1:0]  meas;
    logic                     last;
  } sample_t;

  typedef struct {
    logic [RMS_W-1:0]  rms;
    logic [PEAK_W-1:0] peak;
    logic [MAG_W-1:0]  final_err;
    logic [TIME_W-1:0] settle;
    logic              settled;
    logic [RUN_W-1:0]  samples;
    logic              sat;
  } report_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_HOLD
  } rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [BAND_W-1:0]        cfg_settling_band = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [TIME_W-1:0]        in_sample_time = '0;
  logic signed [POS_W-1:0]  in_target_position = '0;
  logic signed [POS_W-1:0]  in_measured_position = '0;
  logic                     in_end_of_run = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [RMS_W-1:0]         out_rms_error;
  logic [PEAK_W-1:0]        out_peak_overshoot;
  logic [MAG_W-1:0]         out_final_error;
  logic [TIME_W-1:0]        out_settling_time;
  logic                     out_settled;
  logic [RUN_W-1:0]         out_run_samples;
  logic                     out_saturated;

  // pending samples and the reports they should produce
  sample_t sample_queue[$];
  report_t report_queue[$];

  // predicted run state
  logic [BAND_W-1:0]  band_setting = BAND_RESET;
  longint unsigned    err_sq_sum = 0;
  int                 peak_err = 0;
  int unsigned        run_count = 0;
  logic [TIME_W-1:0]  band_start = '0;
  logic               in_band = 1'b0;
  logic               run_sat = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned presented_cnt = 0;
  int unsigned accepted_cnt = 0;

  // sender burst state
  sample_t     next_sample;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // receiver stall state
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_tick = 0;
  int unsigned hold_left = 0;

  step_response_metrics u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_settling_band    (cfg_settling_band),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_time       (in_sample_time),
    .in_target_position   (in_target_position),
    .in_measured_position (in_measured_position),
    .in_end_of_run        (in_end_of_run),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rms_error        (out_rms_error),
    .out_peak_overshoot   (out_peak_overshoot),
    .out_final_error      (out_final_error),
    .out_settling_time    (out_settling_time),
    .out_settled          (out_settled),
    .out_run_samples      (out_run_samples),
    .out_saturated        (out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one accepted sample: update the run figures, and on end of run queue the report
  function automatic void track_sample(input logic [TIME_W-1:0] stamp,
                                       input logic signed [POS_W-1:0] tgt,
                                       input logic signed [POS_W-1:0] meas,
                                       input logic last);
    int              err;
    int unsigned     mag;
    longint unsigned sq;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned cand;
    int              b;
    report_t         rep;
    err = int'(meas) - int'(tgt);
    // error clamps to the 24-bit signed range
    if (err > int'(ERR_MAX)) begin
      err = int'(ERR_MAX);
      run_sat = 1'b1;
    end else if (err < int'(ERR_MIN)) begin
      err = int'(ERR_MIN);
      run_sat = 1'b1;
    end
    mag = (err < 0) ? int'(-err) : int'(err);
    // count full: sample adds nothing to count or sum
    if (run_count < MAX_SAMPLES) begin
      run_count++;
      sq = longint'(mag) * longint'(mag);
      if (err_sq_sum > ~64'd0 - sq) begin
        err_sq_sum = ~64'd0;
        run_sat = 1'b1;
      end else begin
        err_sq_sum += sq;
      end
    end else begin
      run_sat = 1'b1;
    end
    if (err > peak_err) peak_err = err;
    // in-band stretch starts at its first sample
    if (mag <= band_setting) begin
      if (!in_band) begin
        in_band = 1'b1;
        band_start = stamp;
      end
    end else begin
      in_band = 1'b0;
    end
    if (!last) return;
    mean = (run_count != 0) ? err_sq_sum / run_count : 0;
    // integer root, one bit at a time from the top
    root = 0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= mean) root = cand;
    end
    if (root > RMS_MAX) begin
      root = RMS_MAX;
      run_sat = 1'b1;
    end
    rep.rms       = RMS_W'(root);
    rep.peak      = PEAK_W'(peak_err);
    rep.final_err = MAG_W'(mag);
    rep.settle    = in_band ? band_start : stamp;
    rep.settled   = in_band;
    rep.samples   = RUN_W'(run_count);
    rep.sat       = run_sat;
    report_queue.push_back(rep);
    err_sq_sum = 0;
    peak_err   = 0;
    run_count  = 0;
    band_start = '0;
    in_band    = 1'b0;
    run_sat    = 1'b0;
  endfunction

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void push_sample(input logic [TIME_W-1:0] stamp,
                                      input logic signed [POS_W-1:0] tgt,
                                      input logic signed [POS_W-1:0] meas,
                                      input logic last);
    sample_t s;
    s.stamp = stamp;
    s.tgt   = tgt;
    s.meas  = meas;
    s.last  = last;
    sample_queue.push_back(s);
  endfunction

  // sender: bursts of transfers with random gaps, valid held until accepted
  always @(negedge clk) begin
    if (rst_n && !(in_valid && accepted_cnt != presented_cnt)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_sample = sample_queue.pop_front();
        in_sample_time       <= next_sample.stamp;
        in_target_position   <= next_sample.tgt;
        in_measured_position <= next_sample.meas;
        in_end_of_run        <= next_sample.last;
        in_valid             <= 1'b1;
        presented_cnt++;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          // some bursts are long, some followed by no gap at all
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: out_ready driven by a randomly chosen stall pattern
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RX_PERIODIC: begin
        out_ready <= (rx_tick % 5 == 0);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(5, 40);
        end
      end
    endcase
  end

  // monitor: sample transfers feed the prediction, report transfers are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_sample(in_sample_time, in_target_position, in_measured_position,
                     in_end_of_run);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          mismatches++;
          $display("%0t: report expected none got rms_error %0d run_samples %0d",
                   $time, out_rms_error, out_run_samples);
        end else begin
          check_field("rms_error", report_queue[0].rms, out_rms_error);
          check_field("peak_overshoot", report_queue[0].peak, out_peak_overshoot);
          check_field("final_error", report_queue[0].final_err, out_final_error);
          check_field("settling_time", report_queue[0].settle, out_settling_time);
          check_field("settled", report_queue[0].settled, out_settled);
          check_field("run_samples", report_queue[0].samples, out_run_samples);
          check_field("saturated", report_queue[0].sat, out_saturated);
          void'(report_queue.pop_front());
        end
      end
    end
  end

  // band write, only while the block is idle
  task automatic write_band(input logic [BAND_W-1:0] value);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_settling_band <= value;
    do @(posedge clk); while (!cfg_ready);
    band_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all samples taken, all reports in, then let the pipe settle
  task automatic wait_idle();
    while (sample_queue.size() != 0 || accepted_cnt != presented_cnt) @(posedge clk);
    while (report_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // band edges, clamps, root clamp, exits, non-monotonic stamps
  task automatic load_directed();
    push_sample(32'd0, 24'sd0, 24'sd0, 1'b1);
    // error below the range: clamps, final error 2^23, root clamps too
    push_sample(32'hFFFF_FFFF, 24'sh7FFFFF, -24'sh800000, 1'b1);
    // error above the range: clamps, peak at the top
    push_sample(32'd5, -24'sh800000, 24'sh7FFFFF, 1'b1);
    // most negative error without clamp, root still exceeds 23 bits
    push_sample(32'd1, 24'sd0, -24'sh800000, 1'b0);
    push_sample(32'd2, 24'sd0, -24'sh800000, 1'b1);
    // just outside, on the edge, leave, re-enter, stamp going back
    push_sample(32'd10, 24'sd1000, 24'sd1411, 1'b0);
    push_sample(32'd20, 24'sd1000, 24'sd1410, 1'b0);
    push_sample(32'd30, 24'sd1000, 24'sd590, 1'b0);
    push_sample(32'd40, 24'sd1000, 24'sd589, 1'b0);
    push_sample(32'd50, 24'sd1000, 24'sd1000, 1'b0);
    push_sample(32'd45, 24'sd1000, 24'sd1100, 1'b0);
    push_sample(32'd60, 24'sd1000, 24'sd1300, 1'b1);
    // run ends out of band
    push_sample(32'd100, -24'sd5, -24'sd5, 1'b0);
    push_sample(32'd110, -24'sd5, 24'sd4995, 1'b1);
    // negative positions
    push_sample(32'd7, -24'sd1000000, -24'sd999000, 1'b1);
    // peak held through smaller and negative errors
    push_sample(32'd200, 24'sd300000, 24'sd302000, 1'b0);
    push_sample(32'd210, 24'sd300000, 24'sd300050, 1'b0);
    push_sample(32'd220, 24'sd300000, 24'sd297000, 1'b0);
    push_sample(32'd230, 24'sd300000, 24'sd300001, 1'b1);
  endtask

  // mostly step responses settling toward the band, some fully random runs
  task automatic load_random(input int unsigned n);
    int unsigned             made;
    int unsigned             len;
    int unsigned             k;
    int unsigned             nb;
    int                      err0;
    int                      err;
    int                      noise;
    logic [TIME_W-1:0]       stamp;
    logic [TIME_W-1:0]       dt;
    logic signed [POS_W-1:0] tgt;
    made = 0;
    while (made < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      if ($urandom_range(0, 4) == 0) begin
        for (k = 0; k < len; k++)
          push_sample($urandom, POS_W'($urandom), POS_W'($urandom), k == len - 1);
      end else begin
        stamp = $urandom;
        dt    = $urandom_range(1, 5000);
        tgt   = POS_W'($urandom);
        nb    = (band_setting > (1 << 20)) ? (1 << 20) : band_setting + 1;
        err0  = int'($urandom_range(0, 1 << 22));
        if ($urandom_range(0, 1) == 1) err0 = -err0;
        for (k = 0; k < len; k++) begin
          noise = int'($urandom_range(0, 2 * nb)) - int'(nb);
          // tail of the run mostly inside the band
          if (k >= len / 2) noise = noise / 2;
          err = (k < 31) ? (err0 >>> k) + noise : noise;
          if ($urandom_range(0, 7) == 0) err = 0;
          push_sample(stamp, tgt, POS_W'(int'(tgt) + err), k == len - 1);
          stamp += dt;
        end
      end
      made += len;
    end
  endtask

  // main sequence: directed part at reset band, then phases at written bands, the reset band among them
  initial begin
    int ph;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    load_directed();
    wait_idle();
    for (ph = 1; ph <= 6; ph++) begin
      case (ph)
        1:       write_band('0);
        2:       write_band({BAND_W{1'b1}});
        3:       write_band(BAND_RESET);
        4:       write_band(BAND_W'($urandom_range(1, 4000)));
        5:       write_band(BAND_W'($urandom_range(0, 8388607)));
        default: write_band(BAND_W'($urandom_range(0, 50)));
      endcase
      load_random(300);
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
